// ===== src/btlm_pkg.sv =====
// Shared types and constants for the busy time load monitor.
// No dependencies; every other file in src/ refers to it by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package btlm_pkg;

	// field and state widths
	localparam int TS_W    = 32;
	localparam int BUSY_W  = 64;
	localparam int CALLS_W = 32;
	localparam int RATE_W  = 20;
	localparam int ALPHA_W = 17;
	localparam int DENOM_W = CALLS_W + RATE_W;   // calls * 1e6 < 2^52
	localparam int ACC_W   = BUSY_W + RATE_W;    // busy * rate
	localparam int INT_BITS = 7;                 // integer part of the percentage

	// constants of the load formula
	localparam logic [RATE_W-1:0]  US_PER_SECOND = 20'd1000000;
	localparam logic [INT_BITS-1:0] PERCENT_MAX  = 7'd100;
	localparam int                 ALPHA_SHIFT   = 16;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 17'h10000;

	// configuration registers
	localparam int                 ADDR_W         = 3;
	localparam logic               REG_AUDIO_RATE = 1'b0;
	localparam logic               REG_ALPHA      = 1'b1;
	localparam logic [RATE_W-1:0]  RATE_RESET     = 20'd32768;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 17'd6554;

	typedef enum logic [1:0] {
		ACT_ENTER  = 2'd0,
		ACT_EXIT   = 2'd1,
		ACT_SAMPLE = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CMP,
		ST_DIV,
		ST_BMUL,
		ST_BUPD,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic enter;      // latch entry timestamp
		logic do_exit;    // accumulate elapsed time, count a call
		logic start;      // snapshot and clear accumulators, start sample
		logic mul_step;   // one shift-add step of busy * rate
		logic cmp;        // saturation check, set up division
		logic div_step;   // one restoring division step
		logic blend_mul;  // difference times alpha
		logic blend_upd;  // fold step into the average
		logic out_load;   // load the output register
		logic out_read;   // output is a read result (window_empty = 0)
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic win_empty;  // rate or call count is zero
		logic part_ge;    // busy * rate >= calls * 1e6
	} status_t;

endpackage

`default_nettype wire

// ===== src/busy_time_load_monitor_unit.sv =====
// Busy time load monitor, top level: configuration registers and the
// controller/datapath pair. Depends on btlm_pkg, btlm_ctrl, btlm_dp.
//
// Usage:
//  - Request channel: in_valid/in_stall with action and timestamp_us. A request is
//    taken on a clock edge where in_valid is high and in_stall is low.
//  - Result channel: out_valid/out_stall with load_percent and window_empty.
//    Enter and exit requests give no result; sample and read give one each.
//  - Timing: enter, exit and read are handled straight from idle; a read result
//    is valid the cycle after it is taken. A sample with zero calls or zero
//    audio_rate goes from idle straight to the output state. Otherwise a sample
//    runs a shift-add multiply (busy * rate), one step per bit of audio_rate, a
//    compare state, 7 + FRACTION_BITS restoring divide steps, the averaging states
//    and the output state; the divide is skipped when the load saturates at 100
//    percent. The divide and the multiply loop set the sample time; a new request
//    is taken once the result is in the output register.
//  - Stall: the result sits in the output register until out_stall drops.
//    Enter, exit and sample requests are still taken while it waits; a read
//    waits until the register can be reloaded.
//  - Reset (arst_n low): accumulators, entry time and average clear to zero,
//    audio_rate returns to 32768, smoothing_alpha to 6554 (about 0.1).
//  - APB: audio_rate at 0x0, smoothing_alpha at 0x4; write only while idle.
`timescale 1ns / 1ps
`default_nettype none

module busy_time_load_monitor_unit #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	// request channel
	input  wire logic                                         in_valid,
	output logic                                              in_stall,
	input  wire logic [1:0]                                   action,
	input  wire logic [btlm_pkg::TS_W-1:0]                    timestamp_us,
	// result channel
	output logic                                              out_valid,
	input  wire logic                                         out_stall,
	output logic [btlm_pkg::INT_BITS+FRACTION_BITS-1:0]       load_percent,
	output logic                                              window_empty,
	// APB configuration port
	input  wire logic                                         psel,
	input  wire logic                                         penable,
	input  wire logic                                         pwrite,
	input  wire logic [btlm_pkg::ADDR_W-1:0]                  paddr,
	input  wire logic [31:0]                                  pwdata,
	output logic [31:0]                                       prdata,
	output logic                                              pready
);

	localparam int LOAD_W = btlm_pkg::INT_BITS + FRACTION_BITS;

	logic [btlm_pkg::RATE_W-1:0]  audio_rate_q;
	logic [btlm_pkg::ALPHA_W-1:0] alpha_q;
	logic                         cfg_wr;
	btlm_pkg::cmd_t               cmd;
	btlm_pkg::status_t            st;

	assign pready = 1'b1;
	// write lands on the access phase; word index from paddr[2]
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_rate_q <= btlm_pkg::RATE_RESET;
			alpha_q      <= btlm_pkg::ALPHA_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				btlm_pkg::REG_AUDIO_RATE: audio_rate_q <= pwdata[btlm_pkg::RATE_W-1:0];
				btlm_pkg::REG_ALPHA:      alpha_q      <= pwdata[btlm_pkg::ALPHA_W-1:0];
				default: audio_rate_q <= audio_rate_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			btlm_pkg::REG_AUDIO_RATE: prdata = 32'(audio_rate_q);
			btlm_pkg::REG_ALPHA:      prdata = 32'(alpha_q);
			default:                  prdata = '0;
		endcase
	end

	btlm_ctrl #(
		.LOAD_W(LOAD_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	btlm_dp #(
		.FRACTION_BITS(FRACTION_BITS),
		.LOAD_W       (LOAD_W)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.timestamp_us    (timestamp_us),
		.audio_rate      (audio_rate_q),
		.smoothing_alpha (alpha_q),
		.load_percent    (load_percent),
		.window_empty    (window_empty)
	);

endmodule

`default_nettype wire

// ===== src/btlm_ctrl.sv =====
// Sequencer for the busy time load monitor: handshake, state machine, step counter.
// Depends on btlm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btlm_ctrl #(
	parameter int LOAD_W = 23
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        action,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire btlm_pkg::status_t st,
	output btlm_pkg::cmd_t         cmd
);

	localparam int STEPS_MAX = (LOAD_W > btlm_pkg::RATE_W) ? LOAD_W : btlm_pkg::RATE_W;
	localparam int CNT_W     = $clog2(STEPS_MAX);

	btlm_pkg::state_t  state_q, state_d;
	btlm_pkg::action_t act;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic              out_free;
	logic              accept;
	logic              mul_last, div_last;

	assign act       = btlm_pkg::action_t'(action);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != btlm_pkg::ST_IDLE) ||
		(!out_free && act == btlm_pkg::ACT_READ);
	assign accept    = in_valid && !in_stall;
	assign mul_last  = cnt_q == CNT_W'(btlm_pkg::RATE_W - 1);
	assign div_last  = cnt_q == CNT_W'(LOAD_W - 1);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			btlm_pkg::ST_IDLE: begin
				if (accept && act == btlm_pkg::ACT_SAMPLE) begin
					state_d = st.win_empty ? btlm_pkg::ST_OUT : btlm_pkg::ST_MUL;
				end
			end
			btlm_pkg::ST_MUL: begin
				if (mul_last) begin
					state_d = btlm_pkg::ST_CMP;
				end
			end
			btlm_pkg::ST_CMP: begin
				state_d = st.part_ge ? btlm_pkg::ST_BMUL : btlm_pkg::ST_DIV;
			end
			btlm_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = btlm_pkg::ST_BMUL;
				end
			end
			btlm_pkg::ST_BMUL: state_d = btlm_pkg::ST_BUPD;
			btlm_pkg::ST_BUPD: state_d = btlm_pkg::ST_OUT;
			btlm_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = btlm_pkg::ST_IDLE;
				end
			end
			default: state_d = btlm_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			btlm_pkg::ST_IDLE: begin
				if (accept) begin
					case (act)
						btlm_pkg::ACT_ENTER:  cmd.enter   = 1'b1;
						btlm_pkg::ACT_EXIT:   cmd.do_exit = 1'b1;
						btlm_pkg::ACT_SAMPLE: cmd.start   = 1'b1;
						btlm_pkg::ACT_READ: begin
							cmd.out_load = 1'b1;
							cmd.out_read = 1'b1;
						end
						default: cmd = '0;
					endcase
				end
			end
			btlm_pkg::ST_MUL:  cmd.mul_step  = 1'b1;
			btlm_pkg::ST_CMP:  cmd.cmp       = 1'b1;
			btlm_pkg::ST_DIV:  cmd.div_step  = 1'b1;
			btlm_pkg::ST_BMUL: cmd.blend_mul = 1'b1;
			btlm_pkg::ST_BUPD: cmd.blend_upd = 1'b1;
			btlm_pkg::ST_OUT:  cmd.out_load  = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= btlm_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == btlm_pkg::ST_MUL || state_q == btlm_pkg::ST_DIV) &&
				state_d == state_q) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_empty_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && act == btlm_pkg::ACT_SAMPLE && st.win_empty) |=>
		state_q == btlm_pkg::ST_OUT)
		else $error("empty window did not go straight to output");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == btlm_pkg::ST_MUL || state_q == btlm_pkg::ST_DIV) |->
		cnt_q < CNT_W'(STEPS_MAX))
		else $error("step counter out of range");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && act == btlm_pkg::ACT_SAMPLE) |=> in_stall)
		else $error("request taken while a sample is in progress");

endmodule

`default_nettype wire

// ===== src/btlm_dp.sv =====
// Datapath of the busy time load monitor: accumulators, shift-add multiplier,
// restoring divider, averaging and output register. Depends on btlm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btlm_dp #(
	parameter int FRACTION_BITS = 16,
	parameter int LOAD_W        = 23
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire btlm_pkg::cmd_t                   cmd,
	output btlm_pkg::status_t                     st,
	input  wire logic [btlm_pkg::TS_W-1:0]        timestamp_us,
	input  wire logic [btlm_pkg::RATE_W-1:0]      audio_rate,
	input  wire logic [btlm_pkg::ALPHA_W-1:0]     smoothing_alpha,
	output logic [LOAD_W-1:0]                     load_percent,
	output logic                                  window_empty
);

	localparam int DW = btlm_pkg::DENOM_W;
	localparam int AW = btlm_pkg::ACC_W;
	localparam int PW = LOAD_W + btlm_pkg::ALPHA_W;
	localparam logic [LOAD_W-1:0] FULL_SCALE =
		LOAD_W'(btlm_pkg::PERCENT_MAX) << FRACTION_BITS;

	// architectural state
	logic [btlm_pkg::TS_W-1:0]    entry_q;
	logic [btlm_pkg::BUSY_W-1:0]  busy_q;
	logic [btlm_pkg::CALLS_W-1:0] calls_q;
	logic [LOAD_W-1:0]            smooth_q;

	// working registers
	logic [AW-1:0]                mcand_q, acc_q;
	logic [btlm_pkg::RATE_W-1:0]  mplier_q;
	logic [DW-1:0]                denom_q, rem_q;
	logic [LOAD_W-1:0]            fb_q, load_q;
	logic [PW-1:0]                prod_q;
	logic                         up_q, empty_q;
	logic [LOAD_W-1:0]            load_percent_q;
	logic                         window_empty_q;

	logic [btlm_pkg::TS_W-1:0]    elapsed;
	logic [DW-1:0]                denom_d;
	logic [DW+6:0]                part100;
	logic [DW:0]                  trial;
	logic                         trial_ge;
	logic [btlm_pkg::ALPHA_W-1:0] alpha_c;
	logic                         blend_up;
	logic [LOAD_W-1:0]            diff;

	assign elapsed  = timestamp_us - entry_q;
	assign denom_d  = calls_q * btlm_pkg::US_PER_SECOND;
	assign part100  = (DW + 7)'(acc_q[DW-1:0]) * (DW + 7)'(btlm_pkg::PERCENT_MAX);
	assign trial    = {rem_q, fb_q[LOAD_W-1]};
	assign trial_ge = trial >= {1'b0, denom_q};
	assign alpha_c  = smoothing_alpha[btlm_pkg::ALPHA_W-1] ? btlm_pkg::ALPHA_ONE
		: smoothing_alpha;
	assign blend_up = load_q >= smooth_q;
	assign diff     = blend_up ? load_q - smooth_q : smooth_q - load_q;

	assign st.win_empty = (audio_rate == '0) || (calls_q == '0);
	assign st.part_ge   = acc_q >= AW'(denom_q);

	assign load_percent = load_percent_q;
	assign window_empty = window_empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q  <= '0;
			busy_q   <= '0;
			calls_q  <= '0;
			smooth_q <= '0;
		end else begin
			if (cmd.enter) begin
				entry_q <= timestamp_us;
			end
			if (cmd.do_exit) begin
				busy_q <= busy_q + btlm_pkg::BUSY_W'(elapsed);
				if (calls_q != '1) begin
					calls_q <= calls_q + 1'b1;
				end
			end
			if (cmd.start) begin
				busy_q  <= '0;
				calls_q <= '0;
			end
			if (cmd.blend_upd) begin
				if (up_q) begin
					smooth_q <= smooth_q + LOAD_W'(prod_q >> btlm_pkg::ALPHA_SHIFT);
				end else begin
					smooth_q <= smooth_q - LOAD_W'((prod_q +
						PW'(btlm_pkg::ALPHA_ONE - 1'b1)) >> btlm_pkg::ALPHA_SHIFT);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcand_q  <= AW'(busy_q);
			mplier_q <= audio_rate;
			acc_q    <= '0;
			denom_q  <= denom_d;
			empty_q  <= st.win_empty;
		end
		if (cmd.mul_step) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
		if (cmd.cmp) begin
			// rem starts as the part of (busy*rate*100) << F above the quotient bits
			rem_q  <= part100[DW+6:7];
			fb_q   <= {part100[6:0], {FRACTION_BITS{1'b0}}};
			load_q <= st.part_ge ? FULL_SCALE : '0;
		end
		if (cmd.div_step) begin
			rem_q  <= trial_ge ? DW'(trial - {1'b0, denom_q}) : trial[DW-1:0];
			fb_q   <= fb_q << 1;
			load_q <= {load_q[LOAD_W-2:0], trial_ge};
		end
		if (cmd.blend_mul) begin
			prod_q <= PW'(diff) * PW'(alpha_c);
			up_q   <= blend_up;
		end
		if (cmd.out_load) begin
			load_percent_q <= smooth_q;
			window_empty_q <= cmd.out_read ? 1'b0 : empty_q;
		end
	end

	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		smooth_q <= FULL_SCALE)
		else $error("average above full scale");

	a_load_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.blend_mul |-> load_q <= FULL_SCALE)
		else $error("instantaneous load above full scale");

endmodule

`default_nettype wire

// ===== sim/tb_busy_time_load_monitor_unit.sv =====
// Self-checking testbench for busy_time_load_monitor_unit: drives enter/exit/sample/read
// requests and APB register writes, predicts every result in-bench and compares it.
// Depends on btlm_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb_busy_time_load_monitor_unit;

	localparam int          FRACTION_BITS   = 16;
	localparam int          LOAD_W          = btlm_pkg::INT_BITS + FRACTION_BITS;
	localparam logic [31:0] FULL_SCALE      = 32'(btlm_pkg::PERCENT_MAX) << FRACTION_BITS;
	localparam int          SETTLE_CYCLES   = 60;
	localparam int          CYCLE_LIMIT     = 1000000;
	localparam int          RANDOM_REQUESTS = 700;

	typedef struct {
		logic [LOAD_W-1:0] load;
		logic              empty;
	} reading_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request channel
	logic                        in_valid     = 1'b0;
	logic                        in_stall;
	logic [1:0]                  action       = btlm_pkg::ACT_READ;
	logic [btlm_pkg::TS_W-1:0]   timestamp_us = '0;

	// result channel
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [LOAD_W-1:0] load_percent;
	logic              window_empty;

	// APB
	logic                        psel    = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite  = 1'b0;
	logic [btlm_pkg::ADDR_W-1:0] paddr   = '0;
	logic [31:0]                 pwdata  = '0;
	logic [31:0]                 prdata;
	logic                        pready;

	// in-bench copy of the block: registers and state
	logic [btlm_pkg::RATE_W-1:0]  rate_cfg   = btlm_pkg::RATE_RESET;
	logic [btlm_pkg::ALPHA_W-1:0] alpha_cfg  = btlm_pkg::ALPHA_RESET;
	logic [btlm_pkg::TS_W-1:0]    entry_mark = '0;
	logic [btlm_pkg::BUSY_W-1:0]  busy_total = '0;
	logic [btlm_pkg::CALLS_W-1:0] call_total = '0;
	logic [31:0]                  avg_load   = '0;

	reading_t    expected_readings[$];
	reading_t    oldest_reading;
	int          mismatch_count = 0;
	int unsigned requests_sent  = 0;
	int unsigned cycle_count    = 0;
	int unsigned sink_hold      = 0;
	bit          no_idle        = 1'b0;   // both sides run back to back while set
	logic [31:0] clock_us       = '0;     // microsecond time for windows, advanced by run_window

	busy_time_load_monitor_unit #(
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.timestamp_us(timestamp_us),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.load_percent(load_percent),
		.window_empty(window_empty),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Load arithmetic
	// ------------------------------------------------------------------

	// busy * rate * 100 / (calls * 1e6), truncated to the fixed-point grid,
	// clamped at full scale. Done exactly in 128 bits.
	function automatic logic [31:0] instant_load(logic [btlm_pkg::BUSY_W-1:0] busy,
			logic [btlm_pkg::RATE_W-1:0] rate, logic [btlm_pkg::CALLS_W-1:0] calls);
		logic [127:0] denom, part, quo;
		denom = 128'(calls) * 128'(btlm_pkg::US_PER_SECOND);
		part  = 128'(busy) * 128'(rate);
		if (part >= denom)
			return FULL_SCALE;
		quo = (part * 128'(FULL_SCALE)) / denom;
		return (quo > 128'(FULL_SCALE)) ? FULL_SCALE : quo[31:0];
	endfunction

	// old + floor(alpha * (load - old) / 2^16); alpha above one counts as one
	function automatic logic [31:0] blend_average(logic [31:0] old, logic [31:0] load,
			logic [btlm_pkg::ALPHA_W-1:0] alpha_in);
		logic [63:0] weight, step;
		weight = (alpha_in > btlm_pkg::ALPHA_ONE) ? 64'(btlm_pkg::ALPHA_ONE)
			: 64'(alpha_in);
		if (load >= old) begin
			step = (64'(load - old) * weight) >> btlm_pkg::ALPHA_SHIFT;
			return old + step[31:0];
		end
		// rounding up the decrease keeps the floor of a negative step
		step = (64'(old - load) * weight + 64'(btlm_pkg::ALPHA_ONE) - 64'd1)
			>> btlm_pkg::ALPHA_SHIFT;
		return old - step[31:0];
	endfunction

	// Advance the in-bench state by one request, queue its result if it has one.
	function automatic void predict_reading(btlm_pkg::action_t act,
			logic [btlm_pkg::TS_W-1:0] ts);
		reading_t                     r;
		logic [btlm_pkg::BUSY_W-1:0]  busy;
		logic [btlm_pkg::CALLS_W-1:0] calls;
		logic [btlm_pkg::TS_W-1:0]    elapsed;
		case (act)
			btlm_pkg::ACT_ENTER: begin
				entry_mark = ts;
			end
			btlm_pkg::ACT_EXIT: begin
				// elapsed time wraps with the timestamp; call count saturates
				elapsed    = ts - entry_mark;
				busy_total = busy_total + 64'(elapsed);
				if (call_total != '1)
					call_total = call_total + 1'b1;
			end
			btlm_pkg::ACT_SAMPLE: begin
				busy       = busy_total;
				calls      = call_total;
				busy_total = '0;
				call_total = '0;
				r.empty    = (rate_cfg == '0) || (calls == '0);
				if (!r.empty)
					avg_load = blend_average(avg_load,
						instant_load(busy, rate_cfg, calls), alpha_cfg);
				r.load = avg_load[LOAD_W-1:0];
				expected_readings.push_back(r);
			end
			default: begin
				r.load  = avg_load[LOAD_W-1:0];
				r.empty = 1'b0;
				expected_readings.push_back(r);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus plumbing
	// ------------------------------------------------------------------

	function automatic int unsigned draw_wait();
		if (no_idle)
			return 0;
		return $urandom_range(16, 0);
	endfunction

	// Send one request. Called at a rising edge; returns at the edge that took it.
	// Valid stays high into the next request when no gap is drawn.
	task automatic issue_request(input btlm_pkg::action_t act,
			input logic [btlm_pkg::TS_W-1:0] ts);
		int unsigned gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		timestamp_us <= ts;
		predict_reading(act, ts);
		requests_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop sending, let every queued result drain, then let the block go quiet.
	// Also serves as the full hold-off of the sender before register writes.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle, register taken at the access edge
	task automatic write_register(input logic index, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (index == btlm_pkg::REG_AUDIO_RATE)
			rate_cfg = value[btlm_pkg::RATE_W-1:0];
		else
			alpha_cfg = value[btlm_pkg::ALPHA_W-1:0];
	endtask

	task automatic apply_settings(input logic [31:0] rate, input logic [31:0] alpha);
		settle_block();
		write_register(btlm_pkg::REG_AUDIO_RATE, rate);
		write_register(btlm_pkg::REG_ALPHA, alpha);
	endtask

	// Busy time per call that lands around full load at the current rate,
	// so windows hit both the unsaturated and the clamped range.
	function automatic int unsigned busy_span();
		int unsigned period;
		period = (rate_cfg == '0) ? 1000 : 1000000 / rate_cfg;
		if (period == 0)
			period = 1;
		return period + period / 4 + 1;
	endfunction

	// One measurement window: enter/exit pairs with random busy time, closed by a
	// sample. A few pairs are broken (missing or doubled enter) and some noise
	// requests with arbitrary action and timestamp are mixed in.
	task automatic run_window(input int calls);
		int unsigned span, d;
		span = busy_span();
		for (int i = 0; i < calls; i++) begin
			if ($urandom_range(9, 0) == 0)
				issue_request(btlm_pkg::action_t'($urandom_range(3, 0)), $urandom);
			clock_us = clock_us + $urandom_range(2 * span + 5, 0);
			if ($urandom_range(15, 0) != 0)
				issue_request(btlm_pkg::ACT_ENTER, clock_us);
			if ($urandom_range(15, 0) == 0)
				issue_request(btlm_pkg::ACT_ENTER, clock_us + $urandom_range(span, 0));
			d = $urandom_range(span, 0);
			clock_us = clock_us + d;
			issue_request(btlm_pkg::ACT_EXIT, clock_us);
			if ($urandom_range(15, 0) == 0)
				issue_request(btlm_pkg::ACT_READ, $urandom);
		end
		issue_request(btlm_pkg::ACT_SAMPLE, $urandom);
	endtask

	task automatic run_windows(input int count);
		for (int w = 0; w < count; w++) begin
			// mostly short windows, now and then a long one; zero calls gives
			// an empty window
			if ($urandom_range(9, 0) == 0)
				run_window($urandom_range(60, 20));
			else
				run_window($urandom_range(8, 0));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// After reset: zero average, sample with no calls is empty, exit with no
	// enter measures from a zero entry time. Default registers throughout.
	task automatic test_reset_state();
		issue_request(btlm_pkg::ACT_READ, 32'h0);
		issue_request(btlm_pkg::ACT_SAMPLE, 32'h0);
		issue_request(btlm_pkg::ACT_EXIT, 32'd20);
		issue_request(btlm_pkg::ACT_SAMPLE, 32'hFFFF_FFFF);
	endtask

	// Timestamp wrap, zero busy time, the widest elapsed time (clamps at 100%)
	task automatic test_timestamp_edges();
		issue_request(btlm_pkg::ACT_ENTER, 32'hFFFF_FFF0);
		issue_request(btlm_pkg::ACT_EXIT, 32'h0000_0010);
		issue_request(btlm_pkg::ACT_ENTER, 32'h0000_0005);
		issue_request(btlm_pkg::ACT_EXIT, 32'h0000_0005);
		issue_request(btlm_pkg::ACT_SAMPLE, 32'h5555_5555);
		issue_request(btlm_pkg::ACT_ENTER, 32'h0000_0000);
		issue_request(btlm_pkg::ACT_EXIT, 32'hFFFF_FFFF);
		issue_request(btlm_pkg::ACT_SAMPLE, 32'hAAAA_AAAA);
		issue_request(btlm_pkg::ACT_READ, 32'h0);
	endtask

	task automatic extreme_phase(input logic [31:0] rate, input logic [31:0] alpha);
		apply_settings(rate, alpha);
		run_windows(3);
	endtask

	// Register corners: rate zero (every sample empty), rate one, the top of the
	// range and the widest register value; alpha zero (frozen average), exactly
	// one, just above one and the widest value (both treated as one).
	task automatic test_register_extremes();
		no_idle = 1'b0;
		extreme_phase(32'd0, 32'd6554);
		extreme_phase(32'd1, 32'd65536);
		extreme_phase(32'd1000000, 32'd0);
		extreme_phase(32'hF_FFFF, 32'h1_FFFF);
		extreme_phase(32'd48000, 32'd65537);
		extreme_phase(32'd32768, 32'd1);
		extreme_phase(32'd44100, 32'd32768);
	endtask

	// Random registers per phase, random windows, random back-to-back stretches.
	// Some phases start the clock just below the wrap point.
	task automatic test_random_windows();
		int unsigned target;
		logic [31:0] rate, alpha;
		target = requests_sent + RANDOM_REQUESTS;
		while (requests_sent < target) begin
			case ($urandom_range(3, 0))
				0: begin
					rate = $urandom_range(32'hF_FFFF, 0);
				end
				1: begin
					rate = $urandom_range(96000, 8000);
				end
				2: begin
					rate = $urandom_range(200, 1);
				end
				default: begin
					rate = $urandom_range(32'hF_FFFF, 500000);
				end
			endcase
			if ($urandom_range(1, 0) == 0)
				alpha = $urandom_range(65536, 0);
			else
				alpha = $urandom_range(32'h1_FFFF, 0);
			apply_settings(rate, alpha);
			no_idle = ($urandom_range(3, 0) == 0);
			if ($urandom_range(4, 0) == 0)
				clock_us = 32'hFFFF_F000 + $urandom_range(32'hFFF, 0);
			else
				clock_us = $urandom;
			run_windows($urandom_range(8, 3));
		end
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result checking and receiver stall
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Each result taken is checked against the oldest queued one. After a
	// result the receiver stalls for a drawn number of cycles.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				report_mismatch($sformatf("result with none pending: load=%0d empty=%0b",
					load_percent, window_empty));
			end else begin
				oldest_reading = expected_readings.pop_front();
				if (load_percent !== oldest_reading.load)
					report_mismatch($sformatf("load_percent got %0d want %0d",
						load_percent, oldest_reading.load));
				if (window_empty !== oldest_reading.empty)
					report_mismatch($sformatf("window_empty got %0b want %0b",
						window_empty, oldest_reading.empty));
			end
			sink_hold = draw_wait();
		end else if (sink_hold != 0) begin
			sink_hold--;
		end
		out_stall <= (sink_hold != 0);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_timestamp_edges();
		test_register_extremes();
		test_random_windows();

		settle_block();
		if (mismatch_count == 0 && expected_readings.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== busy_time_load_monitor_unit.f =====
src/btlm_pkg.sv
src/btlm_ctrl.sv
src/btlm_dp.sv
src/busy_time_load_monitor_unit.sv
sim/tb_busy_time_load_monitor_unit.sv
